// ===== rtl/core/bmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpd_pkg: shared types and constants of the belt mode pd drive
// fixed-point constants, register map, location codes and drive term bundle
// ----------------------------------------------------------------------------
package bmpd_pkg;

  // configuration channel
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegHalfLength    = 4'd0,
    RegBeltSpeed     = 4'd1,
    RegBeltSpinSpeed = 4'd2,
    RegGainP         = 4'd3,
    RegGainD         = 4'd4,
    RegGainChase     = 4'd5,
    RegGainHoldP     = 4'd6,
    RegGainHoldD     = 4'd7
  } cfg_reg_e;

  // belt locations
  typedef enum logic [1:0] {
    ZoneTop    = 2'd0,
    ZoneLeft   = 2'd1,
    ZoneBottom = 2'd2,
    ZoneRight  = 2'd3
  } zone_e;

  // field widths
  localparam int DataW = 32;
  localparam int LenW  = 31;
  localparam int GainW = 20;

  // reset values of the registers
  localparam logic [LenW-1:0]  HalfLengthRst    = 31'd98304;
  localparam logic [LenW-1:0]  BeltSpeedRst     = 31'd62915;
  localparam logic [LenW-1:0]  BeltSpinSpeedRst = 31'd838861;
  localparam logic [GainW-1:0] GainPRst         = 20'd12800;
  localparam logic [GainW-1:0] GainDRst         = 20'd7680;
  localparam logic [GainW-1:0] GainChaseRst     = 20'd17920;
  localparam logic [GainW-1:0] GainHoldPRst     = 20'd76800;
  localparam logic [GainW-1:0] GainHoldDRst     = 20'd17920;

  // angle reduction, 2pi in q16.16 and a reciprocal for the quotient estimate
  localparam int TwoPiVal   = 411775;
  localparam int RecipShift = 50;
  localparam int QuotW      = 64 - RecipShift;
  localparam logic [31:0] RecipTwoPi = 32'((64'd1 << RecipShift) / 64'(TwoPiVal));
  // 2^31 mod 2pi, undoes the offset that makes the angle unsigned
  localparam int WrapOff = int'((64'd1 << 31) % 64'(TwoPiVal));
  localparam int RemW    = 20;
  localparam int ThW     = 19;

  // error terms and products
  localparam int ErrW  = 35;
  localparam int ProdW = GainW + 1 + ErrW;

  localparam logic signed [ErrW-1:0] FxPi    = 35'sd205887;
  localparam logic signed [ErrW-1:0] FxTwoPi = 35'(TwoPiVal);
  localparam logic signed [ErrW-1:0] FxBuf   = 35'sd1638;
  localparam logic signed [ErrW-1:0] FxEps   = 35'sd655;
  localparam logic signed [ErrW-1:0] FxEps2  = 35'sd66;
  localparam logic [GainW-1:0]       Gain200 = 20'd51200;

  // two gain and error pairs that make one drive
  typedef struct packed {
    logic [GainW-1:0] g1;
    logic [ErrW-1:0]  e1;
    logic [GainW-1:0] g2;
    logic [ErrW-1:0]  e2;
  } drive_terms_t;

endpackage

// ===== rtl/core/bmpd_if.sv =====
// ----------------------------------------------------------------------------
// bmpd_if: valid/ready channels of the belt mode pd drive
// sample input, drive result and configuration write channels
// ----------------------------------------------------------------------------
interface bmpd_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [bmpd_pkg::DataW-1:0] position;
  logic signed [bmpd_pkg::DataW-1:0] angle;
  logic signed [bmpd_pkg::DataW-1:0] velocity;
  logic signed [bmpd_pkg::DataW-1:0] spin_rate;

  modport source (output valid, position, angle, velocity, spin_rate, input ready);
  modport sink   (input valid, position, angle, velocity, spin_rate, output ready);
endinterface

interface bmpd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bmpd_pkg::DataW-1:0] linear_drive;
  logic signed [bmpd_pkg::DataW-1:0] spin_drive;
  logic [1:0]                        zone;
  logic                              fault;

  modport source (output valid, linear_drive, spin_drive, zone, fault, input ready);
  modport sink   (input valid, linear_drive, spin_drive, zone, fault, output ready);
endinterface

interface bmpd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bmpd_pkg::CfgIdxW-1:0]       index;
  logic [bmpd_pkg::CfgDataW-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/belt_mode_pd_drive.sv =====
// ----------------------------------------------------------------------------
// belt_mode_pd_drive: location-scheduled pd drive for a belt
// an accepted word passes through the stage registers 0 to 6 in order to the result port
// throughput: one word per cycle while the result side takes words; each of the seven
// stages has its own valid and moves on whenever the stage after it is empty or moving
// reset: pipeline empty, location top run, registers at their default values
// ----------------------------------------------------------------------------
module belt_mode_pd_drive (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bmpd_in_if.sink              in_i,
  bmpd_out_if.source           out_o,
  bmpd_cfg_if.sink             cfg_i
);

  localparam int Stages = 7;
  localparam int DW     = bmpd_pkg::DataW;
  localparam int EW     = bmpd_pkg::ErrW;
  localparam int PW     = bmpd_pkg::ProdW;
  localparam int RW     = bmpd_pkg::RemW;
  localparam int TW     = bmpd_pkg::ThW;

  // --------------------------------------------------------------------------
  // configuration registers, always ready
  // --------------------------------------------------------------------------
  logic [bmpd_pkg::LenW-1:0]  half_length_q, belt_speed_q, belt_spin_speed_q;
  logic [bmpd_pkg::GainW-1:0] gain_p_q, gain_d_q, gain_chase_q;
  logic [bmpd_pkg::GainW-1:0] gain_hold_p_q, gain_hold_d_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_length_q     <= bmpd_pkg::HalfLengthRst;
      belt_speed_q      <= bmpd_pkg::BeltSpeedRst;
      belt_spin_speed_q <= bmpd_pkg::BeltSpinSpeedRst;
      gain_p_q          <= bmpd_pkg::GainPRst;
      gain_d_q          <= bmpd_pkg::GainDRst;
      gain_chase_q      <= bmpd_pkg::GainChaseRst;
      gain_hold_p_q     <= bmpd_pkg::GainHoldPRst;
      gain_hold_d_q     <= bmpd_pkg::GainHoldDRst;
    end else if (cfg_i.valid) begin
      case (bmpd_pkg::cfg_reg_e'(cfg_i.index))
        bmpd_pkg::RegHalfLength:    half_length_q     <= cfg_i.data[bmpd_pkg::LenW-1:0];
        bmpd_pkg::RegBeltSpeed:     belt_speed_q      <= cfg_i.data[bmpd_pkg::LenW-1:0];
        bmpd_pkg::RegBeltSpinSpeed: belt_spin_speed_q <= cfg_i.data[bmpd_pkg::LenW-1:0];
        bmpd_pkg::RegGainP:         gain_p_q          <= cfg_i.data[bmpd_pkg::GainW-1:0];
        bmpd_pkg::RegGainD:         gain_d_q          <= cfg_i.data[bmpd_pkg::GainW-1:0];
        bmpd_pkg::RegGainChase:     gain_chase_q      <= cfg_i.data[bmpd_pkg::GainW-1:0];
        bmpd_pkg::RegGainHoldP:     gain_hold_p_q     <= cfg_i.data[bmpd_pkg::GainW-1:0];
        bmpd_pkg::RegGainHoldD:     gain_hold_d_q     <= cfg_i.data[bmpd_pkg::GainW-1:0];
        default: ;  // index beyond the map, dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or its word moves on
  // --------------------------------------------------------------------------
  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] en;

  always_comb begin
    en[Stages-1] = !vld_q[Stages-1] || out_o.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: input register, quotient estimate of the offset angle
  // --------------------------------------------------------------------------
  logic [DW-1:0] s0_x_q, s0_a_q, s0_v_q, s0_w_q;
  logic [DW-1:0] s0_u;
  logic [63:0]   s0_prod;

  // angle + 2^31 makes it unsigned, the offset is taken out again in stage 2
  assign s0_u    = {~s0_a_q[DW-1], s0_a_q[DW-2:0]};
  assign s0_prod = 64'(s0_u) * 64'(bmpd_pkg::RecipTwoPi);

  // --------------------------------------------------------------------------
  // stage 1: remainder, below twice 2pi since the estimate is short by one at most
  // --------------------------------------------------------------------------
  logic [DW-1:0]                s1_x_q, s1_v_q, s1_w_q, s1_u_q;
  logic [bmpd_pkg::QuotW-1:0]   s1_q_q;
  logic [DW-1:0]                s1_rem;

  assign s1_rem = s1_u_q - 32'(s1_q_q) * 32'(bmpd_pkg::TwoPiVal);

  // --------------------------------------------------------------------------
  // stage 2: final correction and removal of the offset, angle in [0, 2pi)
  // --------------------------------------------------------------------------
  logic [DW-1:0] s2_x_q, s2_v_q, s2_w_q;
  logic [RW-1:0] s2_r_q;
  logic [RW-1:0] s2_r1, s2_th;

  always_comb begin
    s2_r1 = (s2_r_q >= RW'(bmpd_pkg::TwoPiVal)) ? s2_r_q - RW'(bmpd_pkg::TwoPiVal)
                                                 : s2_r_q;
    s2_th = (s2_r1 >= RW'(bmpd_pkg::WrapOff))
          ? s2_r1 - RW'(bmpd_pkg::WrapOff)
          : s2_r1 + RW'(bmpd_pkg::TwoPiVal - bmpd_pkg::WrapOff);
  end

  // --------------------------------------------------------------------------
  // stage 3: location logic, picks gains and errors and steps the location
  // --------------------------------------------------------------------------
  logic [DW-1:0]          s3_x_q, s3_v_q, s3_w_q;
  logic [TW-1:0]          s3_th_q;
  bmpd_pkg::zone_e        zone_q, zone_d;
  logic                   zone_fire;
  bmpd_pkg::drive_terms_t lin_d, spin_d;
  logic                   fault_d;

  logic signed [EW-1:0] xs, vs, ws, ths, hs, ss, rs;

  assign xs  = EW'($signed(s3_x_q));
  assign vs  = EW'($signed(s3_v_q));
  assign ws  = EW'($signed(s3_w_q));
  assign ths = $signed(EW'(s3_th_q));
  assign hs  = $signed(EW'(half_length_q));
  assign ss  = $signed(EW'(belt_speed_q));
  assign rs  = $signed(EW'(belt_spin_speed_q));

  // the word in stage 3 uses the location as it moves on
  assign zone_fire = vld_q[3] && en[4];

  always_comb begin
    lin_d   = '0;
    spin_d  = '0;
    fault_d = 1'b0;
    case (zone_q)
      bmpd_pkg::ZoneTop: begin
        // spin held at zero angle, the far side of pi wraps round to 2pi
        if (ths > bmpd_pkg::FxPi) begin
          spin_d = '{gain_hold_p_q, bmpd_pkg::FxTwoPi + bmpd_pkg::FxEps - ths,
                     gain_hold_d_q, -ws};
        end else if (ths < bmpd_pkg::FxPi) begin
          spin_d = '{gain_hold_p_q, bmpd_pkg::FxEps - ths, gain_hold_d_q, -ws};
        end else begin
          fault_d = 1'b1;  // exactly pi: no side to turn to
        end
        // run towards the left end, brake near it
        if (xs < bmpd_pkg::FxBuf - hs) begin
          lin_d = '{gain_p_q, -hs - bmpd_pkg::FxBuf - xs, gain_d_q, -vs};
        end else if (vs < -ss - bmpd_pkg::FxEps || vs > bmpd_pkg::FxEps - ss) begin
          lin_d = '{gain_chase_q, -ss - vs, '0, '0};
        end
      end
      bmpd_pkg::ZoneLeft: begin
        lin_d = '{gain_hold_p_q, bmpd_pkg::FxEps - hs - xs, gain_hold_d_q, -vs};
        // turn towards pi, brake near it
        if (ths > bmpd_pkg::FxPi - bmpd_pkg::FxBuf && ths < bmpd_pkg::FxPi + bmpd_pkg::FxBuf) begin
          spin_d = '{gain_p_q, bmpd_pkg::FxPi - ths, gain_d_q, -ws};
        end else if (ws < rs - bmpd_pkg::FxEps || ws > rs + bmpd_pkg::FxEps) begin
          spin_d = '{gain_chase_q, rs - ws, '0, '0};
        end
      end
      bmpd_pkg::ZoneBottom: begin
        spin_d = '{gain_hold_p_q, bmpd_pkg::FxPi - ths, gain_hold_d_q, -ws};
        // run towards the right end, brake near it
        if (xs > hs - bmpd_pkg::FxBuf) begin
          lin_d = '{gain_p_q, hs + bmpd_pkg::FxBuf - xs, gain_d_q, -vs};
        end else if (vs < ss - bmpd_pkg::FxEps || vs > ss + bmpd_pkg::FxEps) begin
          lin_d = '{gain_chase_q, ss - vs, '0, '0};
        end
      end
      bmpd_pkg::ZoneRight: begin
        lin_d = '{gain_hold_p_q, hs - bmpd_pkg::FxEps2 - xs, gain_hold_d_q, -vs};
        // turn on to 2pi, brake near it from either side of the wrap
        if (ths > bmpd_pkg::FxTwoPi - bmpd_pkg::FxBuf) begin
          spin_d = '{bmpd_pkg::Gain200, bmpd_pkg::FxTwoPi - bmpd_pkg::FxEps - ths,
                     gain_d_q, -ws};
        end else if (ths < bmpd_pkg::FxPi - bmpd_pkg::FxBuf) begin
          spin_d = '{bmpd_pkg::Gain200, bmpd_pkg::FxEps - ths, gain_d_q, -ws};
        end else if (ws < rs - bmpd_pkg::FxEps || ws > rs + bmpd_pkg::FxEps) begin
          spin_d = '{gain_chase_q, rs - ws, '0, '0};
        end
      end
      default: ;
    endcase
  end

  // location step after the drive
  always_comb begin
    zone_d = zone_q;
    if (xs < -hs && zone_q == bmpd_pkg::ZoneTop) begin
      zone_d = bmpd_pkg::ZoneLeft;
    end else if (xs > hs && zone_q == bmpd_pkg::ZoneBottom) begin
      zone_d = bmpd_pkg::ZoneRight;
    end else if ((ths <= bmpd_pkg::FxEps || ths >= bmpd_pkg::FxTwoPi - bmpd_pkg::FxEps)
                 && zone_q == bmpd_pkg::ZoneRight) begin
      zone_d = bmpd_pkg::ZoneTop;
    end else if (ths <= bmpd_pkg::FxPi + bmpd_pkg::FxEps && ths >= bmpd_pkg::FxPi - bmpd_pkg::FxEps
                 && zone_q == bmpd_pkg::ZoneLeft) begin
      zone_d = bmpd_pkg::ZoneBottom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= bmpd_pkg::ZoneTop;
    end else if (zone_fire) begin
      zone_q <= zone_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: gain by error products
  // --------------------------------------------------------------------------
  bmpd_pkg::drive_terms_t s4_lin_q, s4_spin_q;
  bmpd_pkg::zone_e        s4_zone_q;
  logic                   s4_fault_q;
  logic signed [PW-1:0]   lp1, lp2, sp1, sp2;

  assign lp1 = PW'($signed({1'b0, s4_lin_q.g1}))  * PW'($signed(s4_lin_q.e1));
  assign lp2 = PW'($signed({1'b0, s4_lin_q.g2}))  * PW'($signed(s4_lin_q.e2));
  assign sp1 = PW'($signed({1'b0, s4_spin_q.g1})) * PW'($signed(s4_spin_q.e1));
  assign sp2 = PW'($signed({1'b0, s4_spin_q.g2})) * PW'($signed(s4_spin_q.e2));

  // --------------------------------------------------------------------------
  // stage 5: sum, floor from q24.24 to q16.16, saturate
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] s5_lp1_q, s5_lp2_q, s5_sp1_q, s5_sp2_q;
  bmpd_pkg::zone_e      s5_zone_q;
  logic                 s5_fault_q;
  logic [DW-1:0]        lin_sat, spin_sat;

  function automatic logic [DW-1:0] sat_drive(logic signed [PW-1:0] p1,
                                               logic signed [PW-1:0] p2);
    logic signed [PW:0] sum;
    logic signed [PW:0] fl;
    logic [DW-1:0]      res;
    sum = (PW+1)'(p1) + (PW+1)'(p2);
    fl  = sum >>> 8;  // arithmetic shift rounds toward minus infinity
    if (fl[PW:DW-1] == '0 || fl[PW:DW-1] == '1) begin
      res = fl[DW-1:0];
    end else begin
      res = fl[PW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return res;
  endfunction

  assign lin_sat  = sat_drive(s5_lp1_q, s5_lp2_q);
  assign spin_sat = sat_drive(s5_sp1_q, s5_sp2_q);

  // --------------------------------------------------------------------------
  // stage 6: result register
  // --------------------------------------------------------------------------
  logic [DW-1:0]   s6_lin_q, s6_spin_q;
  bmpd_pkg::zone_e s6_zone_q;
  logic            s6_fault_q;

  assign out_o.valid        = vld_q[6];
  assign out_o.linear_drive = $signed(s6_lin_q);
  assign out_o.spin_drive   = $signed(s6_spin_q);
  assign out_o.zone         = 2'(s6_zone_q);
  assign out_o.fault        = s6_fault_q;

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_x_q <= in_i.position;
      s0_a_q <= in_i.angle;
      s0_v_q <= in_i.velocity;
      s0_w_q <= in_i.spin_rate;
    end
    if (en[1]) begin
      s1_x_q <= s0_x_q;
      s1_v_q <= s0_v_q;
      s1_w_q <= s0_w_q;
      s1_u_q <= s0_u;
      s1_q_q <= s0_prod[63:bmpd_pkg::RecipShift];
    end
    if (en[2]) begin
      s2_x_q <= s1_x_q;
      s2_v_q <= s1_v_q;
      s2_w_q <= s1_w_q;
      s2_r_q <= s1_rem[RW-1:0];
    end
    if (en[3]) begin
      s3_x_q  <= s2_x_q;
      s3_v_q  <= s2_v_q;
      s3_w_q  <= s2_w_q;
      s3_th_q <= s2_th[TW-1:0];
    end
    if (en[4]) begin
      s4_lin_q   <= lin_d;
      s4_spin_q  <= spin_d;
      s4_zone_q  <= zone_q;
      s4_fault_q <= fault_d;
    end
    if (en[5]) begin
      s5_lp1_q   <= lp1;
      s5_lp2_q   <= lp2;
      s5_sp1_q   <= sp1;
      s5_sp2_q   <= sp2;
      s5_zone_q  <= s4_zone_q;
      s5_fault_q <= s4_fault_q;
    end
    if (en[6]) begin
      s6_lin_q   <= lin_sat;
      s6_spin_q  <= spin_sat;
      s6_zone_q  <= s5_zone_q;
      s6_fault_q <= s5_fault_q;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // location moves only with a word leaving the location stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !zone_fire |=> $stable(zone_q))
    else $error("location changed without a word");

  // location only ever steps to the next one round the belt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    zone_fire && (zone_d != zone_q) |-> 2'(zone_d) == 2'(2'(zone_q) + 2'd1))
    else $error("location skipped or stepped back");

  // reduced angle stays inside one turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> s3_th_q < TW'(bmpd_pkg::TwoPiVal))
    else $error("angle reduction out of range");

  // a fault comes only from the top run and carries no spin drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] && s6_fault_q |-> s6_zone_q == bmpd_pkg::ZoneTop && s6_spin_q == '0)
    else $error("fault word with spin drive or off the top run");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the belt mode pd drive
// feeds belt samples in laps through all four locations, with noise, edge
// cases and several register settings. A built-in predictor models the
// drive, so every result word is checked field by field. Both channels idle
// at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import bmpd_pkg::*;

  // q16.16 constants of the drive law
  localparam longint PiQ       = 205887;
  localparam longint TwoPiQ    = 411775;
  localparam longint BufQ      = 1638;
  localparam longint EpsQ      = 655;
  localparam longint Eps2Q     = 66;
  localparam longint HoldGain  = 51200;   // fixed gain 200 in q12.8
  localparam int     FracShift = 8;       // q24.24 products back to q16.16
  localparam longint MinI      = -64'sd2147483648;
  localparam longint MaxI      = 64'sd2147483647;
  localparam longint TurnSpan  = 5215;    // whole turns of 2pi that fit in 31 bits, each side of zero

  localparam logic [CfgIdxW-1:0] RegUnmapped = 4'd12;

  localparam int LongHold   = 120;
  localparam int ReportCap  = 50;
  localparam int CycleLimit = 200000;

  typedef enum {SetRandom, SetCeiling, SetFloor} reg_set_e;

  typedef struct {
    int position;
    int angle;
    int velocity;
    int spin_rate;
  } belt_sample_t;

  typedef struct packed {
    logic signed [DataW-1:0] lin;
    logic signed [DataW-1:0] spin;
    zone_e                   zone;
    logic                    fault;
  } drive_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bmpd_in_if  in_if ();
  bmpd_out_if out_if ();
  bmpd_cfg_if cfg_if ();

  belt_mode_pd_drive i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers and the location
  logic [LenW-1:0]  reg_half_len   = HalfLengthRst;
  logic [LenW-1:0]  reg_lin_speed  = BeltSpeedRst;
  logic [LenW-1:0]  reg_spin_speed = BeltSpinSpeedRst;
  logic [GainW-1:0] reg_gain_p     = GainPRst;
  logic [GainW-1:0] reg_gain_d     = GainDRst;
  logic [GainW-1:0] reg_gain_chase = GainChaseRst;
  logic [GainW-1:0] reg_hold_p     = GainHoldPRst;
  logic [GainW-1:0] reg_hold_d     = GainHoldDRst;
  zone_e            belt_zone      = ZoneTop;

  belt_sample_t sample_q[$];   // words waiting to be offered
  drive_word_t  drive_q[$];    // predicted drives, oldest first
  belt_sample_t cur_sample;

  bit idle_on = 1'b1;
  int src_gap, snk_gap, hold_left;
  int hold_req, hold_ack;
  int err_cnt, result_cnt, cycle_cnt;

  // ------------------------------------------------------------------------
  // drive law
  // ------------------------------------------------------------------------

  // two gain * error products, floored to q16.16 and saturated to 32 bits
  function automatic longint pd_sum(longint g1, longint e1, longint g2, longint e2);
    longint acc;
    acc = (g1 * e1 + g2 * e2) >>> FracShift;
    if (acc > MaxI) acc = MaxI;
    if (acc < MinI) acc = MinI;
    return acc;
  endfunction

  function automatic bit off_band(longint val, longint target);
    return val < target - EpsQ || val > target + EpsQ;
  endfunction

  // drive for one sample, and the location step that follows it
  function automatic drive_word_t predict_drive(belt_sample_t s);
    drive_word_t r;
    longint x, th, v, w, hl, sp, rs, lin, spin;
    zone_e z;
    x  = s.position;
    v  = s.velocity;
    w  = s.spin_rate;
    th = longint'(s.angle) % TwoPiQ;
    if (th < 0) th += TwoPiQ;
    hl = reg_half_len;
    sp = reg_lin_speed;
    rs = reg_spin_speed;
    lin  = 0;
    spin = 0;
    z = belt_zone;
    r.fault = 1'b0;

    case (z)
      ZoneTop: begin
        // spin held on zero; exactly pi has no side to turn to
        if (th > PiQ) spin = pd_sum(reg_hold_p, TwoPiQ + EpsQ - th, reg_hold_d, -w);
        else if (th < PiQ) spin = pd_sum(reg_hold_p, EpsQ - th, reg_hold_d, -w);
        else r.fault = 1'b1;
        if (x < -hl + BufQ) lin = pd_sum(reg_gain_p, -hl - BufQ - x, reg_gain_d, -v);
        else if (off_band(v, -sp)) lin = pd_sum(reg_gain_chase, -sp - v, 0, 0);
      end
      ZoneLeft: begin
        lin = pd_sum(reg_hold_p, -hl + EpsQ - x, reg_hold_d, -v);
        if (th > PiQ - BufQ && th < PiQ + BufQ)
          spin = pd_sum(reg_gain_p, PiQ - th, reg_gain_d, -w);
        else if (off_band(w, rs)) spin = pd_sum(reg_gain_chase, rs - w, 0, 0);
      end
      ZoneBottom: begin
        spin = pd_sum(reg_hold_p, PiQ - th, reg_hold_d, -w);
        if (x > hl - BufQ) lin = pd_sum(reg_gain_p, hl + BufQ - x, reg_gain_d, -v);
        else if (off_band(v, sp)) lin = pd_sum(reg_gain_chase, sp - v, 0, 0);
      end
      default: begin
        lin = pd_sum(reg_hold_p, hl - Eps2Q - x, reg_hold_d, -v);
        if (th > TwoPiQ - BufQ)
          spin = pd_sum(HoldGain, TwoPiQ - EpsQ - th, reg_gain_d, -w);
        else if (th < PiQ - BufQ) spin = pd_sum(HoldGain, EpsQ - th, reg_gain_d, -w);
        else if (off_band(w, rs)) spin = pd_sum(reg_gain_chase, rs - w, 0, 0);
      end
    endcase

    if (x < -hl && z == ZoneTop) belt_zone = ZoneLeft;
    else if (x > hl && z == ZoneBottom) belt_zone = ZoneRight;
    else if ((th <= EpsQ || th >= TwoPiQ - EpsQ) && z == ZoneRight) belt_zone = ZoneTop;
    else if (th <= PiQ + EpsQ && th >= PiQ - EpsQ && z == ZoneLeft) belt_zone = ZoneBottom;

    r.lin  = lin[DataW-1:0];
    r.spin = spin[DataW-1:0];
    r.zone = z;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  function automatic int rand_between(longint lo, longint hi);
    longint unsigned span, r;
    if (lo < MinI) lo = MinI;
    if (lo > MaxI) lo = MaxI;
    if (hi > MaxI) hi = MaxI;
    if (hi < lo) hi = lo;
    span = hi - lo + 1;
    r = {$urandom, $urandom};
    return int'(lo + longint'(r % span));
  endfunction

  function automatic int rand_near(longint centre, longint spread);
    return rand_between(centre - spread, centre + spread);
  endfunction

  // same angle after reduction, half the time shifted by whole turns
  function automatic int add_turns(longint th);
    longint k;
    if ($urandom_range(0, 1) == 0) return int'(th);
    k = longint'($urandom_range(0, 2 * TurnSpan - 1)) - TurnSpan;
    return int'(th + k * TwoPiQ);
  endfunction

  task automatic push_sample(longint p, longint a, longint v, longint w);
    belt_sample_t s;
    s.position  = int'(p);
    s.angle     = int'(a);
    s.velocity  = int'(v);
    s.spin_rate = int'(w);
    sample_q.push_back(s);
  endtask

  // edge cases, written for the reset register values
  task automatic queue_directed();
    longint hl, sp, rs;
    hl = reg_half_len;
    sp = reg_lin_speed;
    rs = reg_spin_speed;
    // top run
    push_sample(0, 0, 0, 0);
    push_sample(0, PiQ, -sp, 0);                          // fault, speed in band
    push_sample(0, PiQ - TwoPiQ, -sp - EpsQ, 0);          // negative angle folding onto pi
    push_sample(0, PiQ + 5000 * TwoPiQ, -sp + EpsQ + 1, 0);
    push_sample(-hl + BufQ - 1, PiQ + 1, 0, 0);           // first braking position
    push_sample(-hl + BufQ, PiQ - 1, -sp - EpsQ - 1, 0);
    push_sample(MaxI, MaxI, MaxI, MaxI);                  // saturating drives
    push_sample(-hl, MinI, MinI, MinI);                   // on the threshold, no move
    push_sample(MinI, MinI, MinI, MinI);                  // into the left turn
    // left turn
    push_sample(MaxI, PiQ - BufQ + 1, MaxI, MinI);
    push_sample(-hl, PiQ + BufQ - 1, 0, 0);
    push_sample(-hl, PiQ - BufQ, 0, rs);                  // spin in band: zero
    push_sample(-hl, PiQ + BufQ, 0, rs + EpsQ + 1);
    push_sample(-hl, PiQ - EpsQ, 0, 0);                   // into the bottom run
    // bottom run
    push_sample(hl - BufQ + 1, PiQ, sp, 0);
    push_sample(hl - BufQ, MaxI, sp + EpsQ, MaxI);
    push_sample(hl, MinI, MinI, 0);                       // on the threshold, no move
    push_sample(hl + 1, PiQ, sp, 0);                      // into the right turn
    // right turn
    push_sample(hl, TwoPiQ - BufQ + 1, 0, MinI);
    push_sample(hl, PiQ - BufQ - 1, MaxI, MaxI);
    push_sample(hl, PiQ - BufQ, 0, rs + EpsQ + 1);
    push_sample(hl, TwoPiQ - BufQ, 0, rs);
    push_sample(MinI, TwoPiQ - EpsQ, MinI, 0);            // back to the top run
  endtask

  // one round of the belt; now and then a move is left out
  task automatic queue_lap();
    longint hl, sp, rs;
    hl = reg_half_len;
    sp = reg_lin_speed;
    rs = reg_spin_speed;

    repeat ($urandom_range(0, 3))
      push_sample(($urandom_range(0, 1) != 0) ? rand_between(-hl, -hl + BufQ + 300)
                                               : rand_between(-hl, hl),
                  add_turns(($urandom_range(0, 15) == 0) ? PiQ
                                                          : rand_between(0, TwoPiQ - 1)),
                  rand_near(-sp, 2 * EpsQ), rand_near(0, 1 << 18));
    if ($urandom_range(0, 11) != 0)
      push_sample(rand_between(-hl - 3000, -hl - 1), add_turns(rand_between(0, TwoPiQ - 1)),
                  rand_near(-sp, 2 * EpsQ), rand_near(0, 1 << 18));

    repeat ($urandom_range(0, 3))
      push_sample(rand_near(-hl, 3000),
                  add_turns(($urandom_range(0, 1) != 0)
                            ? rand_between(PiQ - BufQ - 200, PiQ - EpsQ - 1)
                            : rand_between(PiQ + EpsQ + 1, PiQ + BufQ + 200)),
                  rand_near(0, 1 << 16), rand_near(rs, 2 * EpsQ));
    if ($urandom_range(0, 11) != 0)
      push_sample(rand_near(-hl, 3000), add_turns(rand_between(PiQ - EpsQ, PiQ + EpsQ)),
                  rand_near(0, 1 << 16), rand_near(rs, 2 * EpsQ));

    repeat ($urandom_range(0, 3))
      push_sample(($urandom_range(0, 1) != 0) ? rand_between(hl - BufQ - 300, hl)
                                               : rand_between(-hl, hl),
                  add_turns(rand_near(PiQ, 20000)),
                  rand_near(sp, 2 * EpsQ), rand_near(0, 1 << 18));
    if ($urandom_range(0, 11) != 0)
      push_sample(rand_between(hl + 1, hl + 3000), add_turns(rand_near(PiQ, 20000)),
                  rand_near(sp, 2 * EpsQ), rand_near(0, 1 << 18));

    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0: push_sample(rand_near(hl, 3000),
                       add_turns(rand_between(TwoPiQ - BufQ - 100, TwoPiQ - EpsQ - 1)),
                       rand_near(0, 1 << 16), rand_near(0, 1 << 20));
        1: push_sample(rand_near(hl, 3000), add_turns(rand_between(EpsQ + 1, PiQ - BufQ + 100)),
                       rand_near(0, 1 << 16), rand_near(0, 1 << 20));
        default: push_sample(rand_near(hl, 3000),
                             add_turns(rand_between(PiQ - BufQ - 100, TwoPiQ - BufQ + 100)),
                             rand_near(0, 1 << 16), rand_near(rs, 2 * EpsQ));
      endcase
    end
    if ($urandom_range(0, 11) != 0)
      push_sample(rand_near(hl, 3000),
                  add_turns(($urandom_range(0, 1) != 0) ? rand_between(0, EpsQ)
                                                         : rand_between(TwoPiQ - EpsQ, TwoPiQ - 1)),
                  rand_near(0, 1 << 16), rand_near(0, 1 << 20));
  endtask

  // mostly laps, the rest raw 32-bit noise
  task automatic queue_random(int n);
    int goal;
    goal = sample_q.size() + n;
    while (sample_q.size() < goal) begin
      if ($urandom_range(0, 9) < 8) queue_lap();
      else repeat ($urandom_range(1, 3)) push_sample($urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // ------------------------------------------------------------------------
  // register writes, only while the pipeline is empty
  // ------------------------------------------------------------------------

  // valid stays up between back-to-back writes; the caller lowers it
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      RegHalfLength:    reg_half_len   = val[LenW-1:0];
      RegBeltSpeed:     reg_lin_speed  = val[LenW-1:0];
      RegBeltSpinSpeed: reg_spin_speed = val[LenW-1:0];
      RegGainP:         reg_gain_p     = val[GainW-1:0];
      RegGainD:         reg_gain_d     = val[GainW-1:0];
      RegGainChase:     reg_gain_chase = val[GainW-1:0];
      RegGainHoldP:     reg_hold_p     = val[GainW-1:0];
      RegGainHoldD:     reg_hold_d     = val[GainW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(reg_set_e how);
    cfg_reg_e r;
    logic [CfgDataW-1:0] val;
    r = r.first();
    do begin
      case (how)
        SetCeiling: val = '1;
        SetFloor:   val = '0;
        default: begin
          case (r)
            RegHalfLength:    val = $urandom_range(1 << 12, 1 << 20);
            RegBeltSpeed:     val = $urandom_range(0, 1 << 20);
            RegBeltSpinSpeed: val = $urandom_range(0, 1 << 21);
            default:          val = $urandom_range(0, 1 << 17);
          endcase
        end
      endcase
      write_reg(r, val);
      r = r.next();
    end while (r != r.first());
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (sample_q.size() != 0 || in_if.valid || drive_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < ReportCap)
      $display("error: word %0d %s got 0x%08h expected 0x%08h", result_cnt, what, got, want);
    err_cnt++;
  endtask

  // ------------------------------------------------------------------------
  // sample driver: offers queued words, predicts each one as it is taken
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        drive_q.push_back(predict_drive(cur_sample));
      end
      // a word on offer stays until taken
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 8) - 1;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur_sample = sample_q.pop_front();
          in_if.position  <= cur_sample.position;
          in_if.angle     <= cur_sample.angle;
          in_if.velocity  <= cur_sample.velocity;
          in_if.spin_rate <= cur_sample.spin_rate;
          in_if.valid     <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // result monitor: checks each word taken, and paces ready
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    drive_word_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (drive_q.size() == 0) begin
          report_mismatch("unexpected word, linear_drive", out_if.linear_drive, '0);
        end else begin
          want = drive_q.pop_front();
          if (out_if.linear_drive !== want.lin)
            report_mismatch("linear_drive", out_if.linear_drive, want.lin);
          if (out_if.spin_drive !== want.spin)
            report_mismatch("spin_drive", out_if.spin_drive, want.spin);
          if (out_if.zone !== want.zone) report_mismatch("zone", out_if.zone, want.zone);
          if (out_if.fault !== want.fault) report_mismatch("fault", out_if.fault, want.fault);
        end
        result_cnt++;
      end
      // a long hold-off on request, else short random stalls
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(1, 8) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // run sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    in_if.valid     = 1'b0;
    in_if.position  = '0;
    in_if.angle     = '0;
    in_if.velocity  = '0;
    in_if.spin_rate = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = RegHalfLength;
    cfg_if.data     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: edge cases, then laps
    queue_directed();
    queue_random(260);
    wait_idle();

    // moderate random settings; an unmapped index must change nothing.
    // the result side then stalls long enough to back the pipeline up
    program_regs(SetRandom);
    write_reg(RegUnmapped, '1);
    cfg_if.valid <= 1'b0;
    hold_req++;
    queue_random(200);
    wait_idle();

    // every register at its ceiling, with bits beyond each width set
    program_regs(SetCeiling);
    cfg_if.valid <= 1'b0;
    push_sample(MaxI, MaxI, MaxI, MaxI);
    push_sample(MinI, MinI, MinI, MinI);
    push_sample(MinI, MaxI, MinI, MaxI);
    push_sample(MaxI, MinI, MaxI, MinI);
    push_sample(0, PiQ, 0, 0);
    queue_random(80);
    wait_idle();

    // everything zero: no length, no speed, no gain
    program_regs(SetFloor);
    cfg_if.valid <= 1'b0;
    queue_random(80);
    wait_idle();

    // closing stretch at full rate on both sides
    program_regs(SetRandom);
    cfg_if.valid <= 1'b0;
    idle_on = 1'b0;
    queue_random(250);
    wait_idle();

    if (drive_q.size() != 0) report_mismatch("words never seen", drive_q.size(), '0);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
